// ===== rtl/cpr_pkg.sv =====
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 6;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ValueW = 2 * DataW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] SyncMask = 8'h80;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VALUE_CMD_FIRST  = 2'd0,
    CFG_VALUE_CMD_SECOND = 2'd1,
    CFG_RETRANSMIT_CODE  = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_idx_e;

  localparam logic [CmdW-1:0] ValueCmdFirstRst  = 3'd5;
  localparam logic [CmdW-1:0] ValueCmdSecondRst = 3'd7;
  localparam logic [CmdW-1:0] RetransmitCodeRst = 3'd7;

  typedef enum logic {
    KIND_RETRANSMIT = 1'b0,
    KIND_COMMAND    = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CmdW-1:0] value_cmd_first;
    logic [CmdW-1:0] value_cmd_second;
    logic [CmdW-1:0] retransmit_code;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  reply_byte;
    logic [CmdW-1:0]   command;
    logic [DataW-1:0]  pin;
    logic [ValueW-1:0] value;
  } res_t;

  function automatic logic parity_ok(input logic [ByteW-1:0] b);
    parity_ok = (b[DataW] == (^b[DataW-1:0]));
  endfunction

  function automatic logic [ByteW-1:0] retransmit_byte(input logic [CmdW-1:0] code);
    logic [ByteW-1:0] r;
    r = SyncMask | {{(ByteW-CmdW){1'b0}}, code};
    r[DataW] = ^r[DataW-1:0];
    retransmit_byte = r;
  endfunction

endpackage

// ===== rtl/cpr_in_stage.sv =====
`timescale 1ns / 1ps

module cpr_in_stage import cpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             advance_i,
  output logic             valid_o,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

// ===== rtl/cpr_decode.sv =====
`timescale 1ns / 1ps

module cpr_decode import cpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PIN  = 2'd1,
    PH_HI   = 2'd2,
    PH_LO   = 2'd3
  } phase_e;

  phase_e            phase_q, phase_d;
  logic [CmdW-1:0]   cmd_q, cmd_d;
  logic [DataW-1:0]  pin_q, pin_d;
  logic [DataW-1:0]  upper_q, upper_d;
  logic [ValueW-1:0] value_q, value_d;

  logic             is_cmd;
  logic             par_ok;
  logic             has_value;
  logic             emit_retx;
  logic             emit_cmd;
  logic [DataW-1:0] data6;

  assign is_cmd    = byte_i[ByteW-1];
  assign par_ok    = parity_ok(byte_i);
  assign data6     = byte_i[DataW-1:0];
  assign has_value = (cmd_q == cfg_i.value_cmd_first) || (cmd_q == cfg_i.value_cmd_second);

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    pin_d     = pin_q;
    upper_d   = upper_q;
    value_d   = value_q;
    emit_retx = 1'b0;
    emit_cmd  = 1'b0;
    if (phase_q == PH_IDLE) begin
      if (is_cmd) begin
        if (!par_ok) begin
          emit_retx = 1'b1;
        end else begin
          cmd_d   = byte_i[CmdW-1:0];
          phase_d = PH_PIN;
        end
      end
    end else if (is_cmd) begin
      phase_d = PH_IDLE;
    end else if (!par_ok) begin
      phase_d   = PH_IDLE;
      emit_retx = 1'b1;
    end else begin
      unique case (phase_q)
        PH_PIN: begin
          pin_d = data6;
          if (has_value) begin
            phase_d = PH_HI;
          end else begin
            phase_d  = PH_IDLE;
            emit_cmd = 1'b1;
          end
        end
        PH_HI: begin
          upper_d = data6;
          phase_d = PH_LO;
        end
        default: begin
          value_d  = {upper_q, data6};
          phase_d  = PH_IDLE;
          emit_cmd = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      pin_q   <= '0;
      upper_q <= '0;
      value_q <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      pin_q   <= pin_d;
      upper_q <= upper_d;
      value_q <= value_d;
    end
  end

  always_comb begin
    res_o = '0;
    if (emit_cmd) begin
      res_o.kind    = KIND_COMMAND;
      res_o.command = cmd_d;
      res_o.pin     = pin_d;
      res_o.value   = value_d;
    end else begin
      res_o.kind       = KIND_RETRANSMIT;
      res_o.reply_byte = retransmit_byte(cfg_i.retransmit_code);
    end
  end

  assign res_valid_o = emit_retx || emit_cmd;

endmodule

// ===== rtl/command_packet_receiver.sv =====
// path from byte accept to result valid: input register, then result register
// throughput: one byte per cycle while results are taken; a result waiting to be taken holds
// the byte in the input register and drops in_ready_o
// a byte that completes a packet, or a checked byte with bad parity, gives one result
// reset clears phase, held fields and assembled value, and loads the register defaults
`timescale 1ns / 1ps

module command_packet_receiver import cpr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CmdW-1:0]     cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ByteW-1:0]    in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                kind_o,
  output logic [ByteW-1:0]    reply_byte_o,
  output logic [CmdW-1:0]     command_o,
  output logic [DataW-1:0]    pin_o,
  output logic [ValueW-1:0]   value_o
);

  cfg_t             cfg_q;
  logic             stage_valid;
  logic [ByteW-1:0] stage_byte;
  logic             advance;
  logic             res_valid;
  res_t             res;
  logic             out_valid_q;
  res_t             out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.value_cmd_first  <= ValueCmdFirstRst;
      cfg_q.value_cmd_second <= ValueCmdSecondRst;
      cfg_q.retransmit_code  <= RetransmitCodeRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_VALUE_CMD_FIRST:  cfg_q.value_cmd_first  <= cfg_data_i;
        CFG_VALUE_CMD_SECOND: cfg_q.value_cmd_second <= cfg_data_i;
        CFG_RETRANSMIT_CODE:  cfg_q.retransmit_code  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance = stage_valid && (!out_valid_q || out_ready_i);

  cpr_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .byte_o     (stage_byte)
  );

  cpr_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .byte_i      (stage_byte),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_q.kind;
  assign reply_byte_o = out_q.reply_byte;
  assign command_o    = out_q.command;
  assign pin_o        = out_q.pin;
  assign value_o      = out_q.value;

  a_retx_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_RETRANSMIT) |->
      reply_byte_o[ByteW-1] && (command_o == '0) && (pin_o == '0) && (value_o == '0))
    else $error("retransmit result carries command fields");

  a_retx_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_RETRANSMIT) |->
      (reply_byte_o[DataW] == (^reply_byte_o[DataW-1:0])))
    else $error("retransmit byte parity wrong");

  a_cmd_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_COMMAND) |-> (reply_byte_o == '0))
    else $error("command result carries reply byte");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> stage_valid && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule
